FILE: design/fwt_pkg.sv
package fwt_pkg;

   localparam int BucketCountDef = 64;
   localparam int WaysDef        = 8;
   localparam int MaxResults     = 8;

   localparam logic [31:0] LifetimeReset = 32'd3600;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_DEL   = 3'd1,
      OP_FAIL  = 3'd2,
      OP_SWEEP = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   // result action codes
   localparam logic [2:0] ACT_DONE    = 3'd0;
   localparam logic [2:0] ACT_INSTALL = 3'd1;
   localparam logic [2:0] ACT_REMOVE  = 3'd2;
   localparam logic [2:0] ACT_FULL    = 3'd3;
   localparam logic [2:0] ACT_NOTFND  = 3'd4;

   // register indexes
   localparam logic CSR_LIFETIME = 1'b0;
   localparam logic CSR_INST_OFF = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [31:0] source;
      logic [31:0] dest;
      logic [31:0] created;
      logic [31:0] expiry;
      logic [15:0] refs;
      logic        failed;
   } slot_type;

   // one result word
   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] source;
      logic [31:0] dest;
      logic [31:0] created;
      logic [31:0] expiry;
      logic [15:0] refs;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT,
      ST_DONE
   } state_type;

endpackage

FILE: design/fwt_slot_mem.sv
module fwt_slot_mem
   import fwt_pkg::*;
#(
   parameter int Depth = BucketCountDef * WaysDef
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   wr_addr,
   input  slot_type                                       wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   rd_addr,
   output slot_type                                       rd_data
);

   slot_type mem [Depth];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/flow_whitelist_table_with_aging_top.sv
// Flow whitelist table: pairs hashed by source mod BUCKET_COUNT into buckets of
// WAYS_PER_BUCKET slots held in one memory with a registered read port. One word
// is taken at a time. After reset the table is swept clean, one slot a cycle,
// during which req_stall is high. A word then reads its bucket one way a cycle and
// then settles the scan. Add and failure report decide and load the result, after
// which the next word can be taken. Delete, sweep and clear walk the ways one a
// cycle up to the last way removed, one result per removal; with nothing removed
// they give one empty result. An unknown op gives one empty result without reading
// its bucket. A held result (rsp_stall high) holds the walk or the decision for as
// long as it lasts.
module flow_whitelist_table_with_aging_top
   import fwt_pkg::*;
#(
   parameter int BUCKET_COUNT    = BucketCountDef,
   parameter int WAYS_PER_BUCKET = WaysDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_dest_addr,
   input  logic [31:0] req_now_time,
   input  logic [5:0]  req_bucket_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_rule_source,
   output logic [31:0] rsp_rule_dest,
   output logic [31:0] rsp_stamp_time,
   output logic [31:0] rsp_expiry_time,
   output logic [15:0] rsp_reference_count,
   output logic        rsp_last_of_run
);

   localparam int Depth = BUCKET_COUNT * WAYS_PER_BUCKET;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int BW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int WW    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
   localparam int WCW   = $clog2(WAYS_PER_BUCKET + 1);
   localparam int RCW   = $clog2(MaxResults + 1);

   // configuration
   logic [31:0] lifetime_ff;
   logic        inst_off_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LifetimeReset;
         inst_off_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LIFETIME: lifetime_ff <= csr_data;
            CSR_INST_OFF: inst_off_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clearing pass
   logic          clr_busy_ff, clr_busy_in;
   logic [AW:0]   clr_cnt_ff, clr_cnt_in;

   state_type     state_ff, state_in;
   logic [2:0]    op_ff;
   logic [31:0]   src_ff, dst_ff, now_ff;
   logic [BW-1:0] bkt_ff;
   logic [WCW-1:0] rd_way_ff, rd_way_in;   // next way to read
   logic [WCW-1:0] sc_way_ff, sc_way_in;   // way whose data is arriving
   logic           sc_on_ff, sc_on_in;
   // per-way bookkeeping
   logic           hit_ff;
   logic [WW-1:0]  hit_way_ff;
   slot_type       hit_slot_ff;
   logic           free_ff;
   logic [WW-1:0]  free_way_ff;
   logic [WAYS_PER_BUCKET-1:0] rm_ff;
   slot_type       rm_slot_ff [WAYS_PER_BUCKET];
   logic [RCW-1:0] rm_cnt_ff;
   logic           stop_ff;
   // emit
   logic [WCW-1:0] em_way_ff, em_way_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_v_ff, rsp_v_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   slot_type      wr_data, rd_data;

   fwt_slot_mem #(.Depth(Depth)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [AW-1:0] base;
   assign base = AW'(bkt_ff) * AW'(WAYS_PER_BUCKET);

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || clr_busy_ff;

   logic rsp_free;
   assign rsp_free = !rsp_v_ff || !rsp_stall;

   // match tests on arriving way
   logic pair_eq, src_eq, expired, want_rm;
   always_comb begin
      pair_eq = rd_data.source == src_ff && rd_data.dest == dst_ff;
      src_eq  = rd_data.source == src_ff;
      expired = (now_ff - rd_data.created) > (rd_data.expiry - rd_data.created);
      want_rm = 1'b0;
      case (op_ff)
         OP_DEL:   want_rm = src_eq && (dst_ff == 32'd0 || rd_data.dest == dst_ff);
         OP_SWEEP: want_rm = expired;
         OP_CLEAR: want_rm = 1'b1;
         default:  want_rm = 1'b0;
      endcase
      want_rm = want_rm && rd_data.valid && !stop_ff && (rm_cnt_ff < RCW'(MaxResults));
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         src_ff    <= req_source_addr;
         dst_ff    <= req_dest_addr;
         now_ff    <= req_now_time;
         bkt_ff    <= (req_op == OP_ADD || req_op == OP_DEL || req_op == OP_FAIL) ?
                      BW'(req_source_addr % BUCKET_COUNT) :
                      BW'(req_bucket_index % BUCKET_COUNT);
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         rm_ff     <= '0;
         rm_cnt_ff <= '0;
         stop_ff   <= 1'b0;
      end else if (sc_on_ff) begin
         if (rd_data.valid && pair_eq && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_way_ff  <= WW'(sc_way_ff);
            hit_slot_ff <= rd_data;
         end
         if (!rd_data.valid && !free_ff && !hit_ff) begin
            free_ff     <= 1'b1;
            free_way_ff <= WW'(sc_way_ff);
         end
         if (want_rm) begin
            rm_ff[WW'(sc_way_ff)]      <= 1'b1;
            rm_slot_ff[WW'(sc_way_ff)] <= rd_data;
            rm_cnt_ff                  <= rm_cnt_ff + RCW'(1);
            if (op_ff == OP_DEL && dst_ff != 32'd0) stop_ff <= 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         rsp_v_ff    <= 1'b0;
         sc_on_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
         rsp_v_ff    <= rsp_v_in;
         sc_on_ff    <= sc_on_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_way_ff <= rd_way_in;
      sc_way_ff <= sc_way_in;
      em_way_ff <= em_way_in;
      rsp_ff    <= rsp_in;
   end

   // next state, memory access and results
   always_comb begin
      slot_type ns;
      logic [WW-1:0] wsel;
      state_in    = state_ff;
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_way_in   = rd_way_ff;
      sc_way_in   = rd_way_ff;
      sc_on_in    = 1'b0;
      em_way_in   = em_way_ff;
      rsp_in      = rsp_ff;
      rsp_v_in    = rsp_v_ff && rsp_stall;
      wr_en       = 1'b0;
      wr_addr     = base + AW'(hit_way_ff);
      wr_data     = hit_slot_ff;
      rd_addr     = base + AW'(rd_way_ff);
      ns          = hit_slot_ff;
      wsel        = WW'(em_way_ff);

      if (clr_busy_ff) begin
         wr_en      = 1'b1;
         wr_addr    = AW'(clr_cnt_ff);
         wr_data    = '0;
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (AW+1)'(Depth - 1)) clr_busy_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_way_in = '0;
               state_in  = (req_op <= OP_CLEAR) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            // one way a cycle; data lands next cycle
            if (rd_way_ff < WCW'(WAYS_PER_BUCKET)) begin
               sc_on_in  = 1'b1;
               sc_way_in = rd_way_ff;
               rd_way_in = rd_way_ff + 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in  = (op_ff == OP_ADD || op_ff == OP_FAIL) ? ST_DECIDE : ST_EMIT;
            em_way_in = '0;
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_v_in       = 1'b1;
               rsp_in         = '0;
               rsp_in.last    = 1'b1;
               rsp_in.source  = src_ff;
               rsp_in.dest    = dst_ff;
               state_in       = ST_IDLE;
               if (hit_ff) begin
                  wr_en = 1'b1;
                  if (op_ff == OP_FAIL) begin
                     ns.failed     = 1'b1;
                     rsp_in.action = ACT_DONE;
                  end else begin
                     if (ns.refs != 16'hFFFF) ns.refs = ns.refs + 16'd1;
                     rsp_in.action = ns.failed ? ACT_INSTALL : ACT_DONE;
                     ns.failed     = 1'b0;
                  end
                  wr_data         = ns;
                  rsp_in.created  = ns.created;
                  rsp_in.expiry   = ns.expiry;
                  rsp_in.refs     = ns.refs;
                  rsp_in.source   = ns.source;
                  rsp_in.dest     = ns.dest;
               end else if (op_ff == OP_FAIL) begin
                  rsp_in.action = ACT_NOTFND;
               end else begin
                  rsp_in.created = now_ff;
                  rsp_in.expiry  = now_ff + lifetime_ff;
                  if (!free_ff) begin
                     rsp_in.action = ACT_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = base + AW'(free_way_ff);
                     wr_data        = '{1'b1, src_ff, dst_ff, now_ff,
                                        now_ff + lifetime_ff, 16'd0, 1'b0};
                     rsp_in.action  = inst_off_ff ? ACT_DONE : ACT_INSTALL;
                  end
               end
            end
         end
         ST_EMIT: begin
            // walk removal marks; one removal per cycle while the result register is free
            if (em_way_ff >= WCW'(WAYS_PER_BUCKET)) begin
               state_in = ST_IDLE;
            end else if (!rm_ff[wsel]) begin
               em_way_in = em_way_ff + 1'b1;
               if (rm_cnt_ff == '0) state_in = ST_DONE;
            end else if (rsp_free) begin
               wr_en          = 1'b1;
               wr_addr        = base + AW'(wsel);
               wr_data        = rm_slot_ff[wsel];
               wr_data.valid  = 1'b0;
               rsp_v_in       = 1'b1;
               rsp_in.action  = ACT_REMOVE;
               rsp_in.source  = rm_slot_ff[wsel].source;
               rsp_in.dest    = rm_slot_ff[wsel].dest;
               rsp_in.created = rm_slot_ff[wsel].created;
               rsp_in.expiry  = rm_slot_ff[wsel].expiry;
               rsp_in.refs    = rm_slot_ff[wsel].refs;
               // last if no mark above
               rsp_in.last    = ((rm_ff >> wsel) >> 1) == '0;
               em_way_in      = em_way_ff + 1'b1;
               if (rsp_in.last) state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            // single empty answer
            if (rsp_free) begin
               rsp_v_in      = 1'b1;
               rsp_in        = '0;
               rsp_in.last   = 1'b1;
               rsp_in.action = ACT_DONE;
               if (op_ff == OP_DEL) begin
                  rsp_in.action = ACT_NOTFND;
                  rsp_in.source = src_ff;
                  rsp_in.dest   = dst_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid           = rsp_v_ff;
   assign rsp_action          = rsp_ff.action;
   assign rsp_rule_source     = rsp_ff.source;
   assign rsp_rule_dest       = rsp_ff.dest;
   assign rsp_stamp_time      = rsp_ff.created;
   assign rsp_expiry_time     = rsp_ff.expiry;
   assign rsp_reference_count = rsp_ff.refs;
   assign rsp_last_of_run     = rsp_ff.last;

   // no word taken during the clearing pass
   a_no_accept_clr: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept) else $error("word accepted while clearing");
   // removals never exceed the per-word limit while a word is in hand
   a_rm_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> rm_cnt_ff <= RCW'(MaxResults))
      else $error("removal count overflow");
   // a held result stays valid while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_stall |=> rsp_v_ff) else $error("result dropped");

endmodule

FILE: tb/testbench.sv
module testbench
   import fwt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUCKETS = 64;
   localparam int NWAYS    = 8;
   localparam int NSLOTS   = NBUCKETS * NWAYS;

   // one request word
   typedef struct {
      logic [2:0]  op;
      logic [31:0] source;
      logic [31:0] dest;
      logic [31:0] now;
      logic [5:0]  bucket;
   } req_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [31:0] req_source_addr = '0;
   logic [31:0] req_dest_addr = '0;
   logic [31:0] req_now_time = '0;
   logic [5:0]  req_bucket_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_rule_source;
   logic [31:0] rsp_rule_dest;
   logic [31:0] rsp_stamp_time;
   logic [31:0] rsp_expiry_time;
   logic [15:0] rsp_reference_count;
   logic        rsp_last_of_run;

   flow_whitelist_table_with_aging_top uut (.*);

   always #4 clock = ~clock;

   // shadow of the table and registers
   logic        tbl_valid [NSLOTS];
   logic [31:0] tbl_source [NSLOTS];
   logic [31:0] tbl_dest [NSLOTS];
   logic [31:0] tbl_created [NSLOTS];
   logic [31:0] tbl_expiry [NSLOTS];
   logic [15:0] tbl_refs [NSLOTS];
   logic        tbl_failed [NSLOTS];
   logic [31:0] lifetime = LifetimeReset;
   logic        install_off = 1'b0;

   req_word_type pending_words[$];
   rsp_type     awaited_results[$];
   int          errors = 0;
   int          words_sent = 0;
   int          words_offered = 0;
   int          results_seen = 0;
   int          removals_seen = 0;
   int          hold_cycles = 0;
   bit          long_hold = 0;
   bit          pause_send = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   // recently used pairs, so that random words revisit them
   logic [31:0] pair_src[$];
   logic [31:0] pair_dst[$];

   task automatic report(input string what, input rsp_type got, input rsp_type want);
      errors++;
      $display("mismatch %s: got act %0d %h %h %h %h %0d %b, want act %0d %h %h %h %h %0d %b",
               what, got.action, got.source, got.dest, got.created, got.expiry,
               got.refs, got.last, want.action, want.source, want.dest,
               want.created, want.expiry, want.refs, want.last);
   endtask

   function automatic rsp_type slot_result(input logic [2:0] act, input int i);
      rsp_type r;
      r = '{act, tbl_source[i], tbl_dest[i], tbl_created[i], tbl_expiry[i],
            tbl_refs[i], 1'b0};
      return r;
   endfunction

   // work out the results of one accepted word and update the shadow table
   task automatic predict_table_step(input req_word_type w);
      rsp_type outs[$];
      int      base, i, slot_free, way;
      bit      found, have_free;
      logic [2:0] act;
      outs = {};
      found = 0;
      have_free = 0;
      slot_free = 0;
      i = 0;
      if (w.op inside {OP_ADD, OP_DEL, OP_FAIL}) base = (w.source % NBUCKETS) * NWAYS;
      else base = (w.bucket % NBUCKETS) * NWAYS;
      if (w.op == OP_ADD || w.op == OP_FAIL) begin
         for (way = 0; way < NWAYS; way++) begin
            if (tbl_valid[base + way]) begin
               if (tbl_source[base + way] == w.source && tbl_dest[base + way] == w.dest) begin
                  found = 1;
                  i = base + way;
                  break;
               end
            end else if (!have_free) begin
               have_free = 1;
               slot_free = base + way;
            end
         end
         if (found && w.op == OP_FAIL) begin
            tbl_failed[i] = 1'b1;
            outs.push_back(slot_result(ACT_DONE, i));
         end else if (found) begin
            act = ACT_DONE;
            if (tbl_refs[i] != 16'hFFFF) tbl_refs[i]++;
            if (tbl_failed[i]) begin
               act = ACT_INSTALL;
               tbl_failed[i] = 1'b0;
            end
            outs.push_back(slot_result(act, i));
         end else if (w.op == OP_FAIL) begin
            outs.push_back('{ACT_NOTFND, w.source, w.dest, 32'd0, 32'd0, 16'd0, 1'b0});
         end else if (!have_free) begin
            outs.push_back('{ACT_FULL, w.source, w.dest, w.now, w.now + lifetime,
                             16'd0, 1'b0});
         end else begin
            tbl_valid[slot_free] = 1'b1;
            tbl_source[slot_free] = w.source;
            tbl_dest[slot_free] = w.dest;
            tbl_created[slot_free] = w.now;
            tbl_expiry[slot_free] = w.now + lifetime;
            tbl_refs[slot_free] = '0;
            tbl_failed[slot_free] = 1'b0;
            outs.push_back(slot_result(install_off ? ACT_DONE : ACT_INSTALL, slot_free));
         end
      end else if (w.op inside {OP_DEL, OP_SWEEP, OP_CLEAR}) begin
         for (way = 0; way < NWAYS && outs.size() < MaxResults; way++) begin
            i = base + way;
            if (!tbl_valid[i]) continue;
            if (w.op == OP_DEL) begin
               if (tbl_source[i] != w.source) continue;
               if (w.dest != 0 && tbl_dest[i] != w.dest) continue;
               outs.push_back(slot_result(ACT_REMOVE, i));
               tbl_valid[i] = 1'b0;
               if (w.dest != 0) break;
            end else if (w.op == OP_SWEEP) begin
               if (32'(w.now - tbl_created[i]) > 32'(tbl_expiry[i] - tbl_created[i])) begin
                  outs.push_back(slot_result(ACT_REMOVE, i));
                  tbl_valid[i] = 1'b0;
               end
            end else begin
               outs.push_back(slot_result(ACT_REMOVE, i));
               tbl_valid[i] = 1'b0;
            end
         end
         if (outs.size() == 0) begin
            if (w.op == OP_DEL)
               outs.push_back('{ACT_NOTFND, w.source, w.dest, 32'd0, 32'd0, 16'd0, 1'b0});
            else
               outs.push_back('{ACT_DONE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0});
         end
      end else begin
         outs.push_back('{ACT_DONE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0});
      end
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[k]) awaited_results.push_back(outs[k]);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // accepted words are predicted at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_table_step('{req_op, req_source_addr, req_dest_addr, req_now_time,
                              req_bucket_index});
         words_sent++;
      end
   end

   // sender: offer words from the pending queue at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && words_sent != words_offered) begin
            // hold the stalled word
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 && !pause_send) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_op <= w.op;
            req_source_addr <= w.source;
            req_dest_addr <= w.dest;
            req_now_time <= w.now;
            req_bucket_index <= w.bucket;
            words_offered++;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random gaps, plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold && hold_cycles < 300) begin
            hold_cycles++;
            rsp_stall <= 1'b1;
         end else begin
            if (long_hold) long_hold = 0;
            if (recv_gap > 0) begin
               recv_gap--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type got, want;
         got = '{rsp_action, rsp_rule_source, rsp_rule_dest, rsp_stamp_time,
                 rsp_expiry_time, rsp_reference_count, rsp_last_of_run};
         results_seen++;
         if (rsp_action == ACT_REMOVE) removals_seen++;
         if (awaited_results.size() == 0) begin
            report("unexpected result", got, got);
         end else begin
            want = awaited_results.pop_front();
            if (got.action != want.action) report("action", got, want);
            else if (got.source != want.source) report("rule_source", got, want);
            else if (got.dest != want.dest) report("rule_dest", got, want);
            else if (got.created != want.created) report("stamp_time", got, want);
            else if (got.expiry != want.expiry) report("expiry_time", got, want);
            else if (got.refs != want.refs) report("reference_count", got, want);
            else if (got.last != want.last) report("last_of_run", got, want);
         end
      end
   end

   function automatic req_word_type mk(input logic [2:0] op, input logic [31:0] s,
                                       input logic [31:0] d, input logic [31:0] t,
                                       input logic [5:0] b);
      req_word_type w;
      w = '{op, s, d, t, b};
      return w;
   endfunction

   // random word, biased towards pairs already in play
   function automatic req_word_type random_word(input logic [31:0] t);
      int r, j;
      logic [31:0] s, d;
      r = $urandom_range(0, 99);
      if (pair_src.size() > 0 && $urandom_range(0, 2) != 0) begin
         j = $urandom_range(0, pair_src.size() - 1);
         s = pair_src[j];
         d = pair_dst[j];
      end else begin
         // few buckets, so they fill and collide
         s = {26'($urandom()), 6'd0} | 32'($urandom_range(0, 3));
         d = $urandom();
         if ($urandom_range(0, 9) == 0) d = 32'hFFFF_FFFF;
         pair_src.push_back(s);
         pair_dst.push_back(d);
         if (pair_src.size() > 24) begin
            void'(pair_src.pop_front());
            void'(pair_dst.pop_front());
         end
      end
      if (r < 45) return mk(OP_ADD, s, d, t, 6'($urandom()));
      if (r < 60) return mk(OP_DEL, s, ($urandom_range(0, 3) == 0) ? 32'd0 : d, t,
                            6'($urandom()));
      if (r < 72) return mk(OP_FAIL, s, d, t, 6'($urandom()));
      if (r < 86) return mk(OP_SWEEP, $urandom(), $urandom(), t,
                            ($urandom_range(0, 3) == 0) ? 6'($urandom()) :
                            6'($urandom_range(0, 3)));
      if (r < 95) return mk(OP_CLEAR, $urandom(), $urandom(), t, 6'($urandom_range(0, 5)));
      return mk(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                6'($urandom()));
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || awaited_results.size() > 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_LIFETIME) lifetime = val;
      else install_off = val[0];
   endtask

   initial begin
      logic [31:0] t;
      int ph;
      for (int i = 0; i < NSLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_failed[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fill bucket 5 to overflow, refcount, failure flow, removals
      for (int k = 0; k < 8; k++)
         pending_words.push_back(mk(OP_ADD, 32'h0A00_0005 + (k << 6), 32'h0B00_0000 + k,
                                    32'd100, 6'd0));
      pending_words.push_back(mk(OP_ADD, 32'hFFFF_FFC5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0));
      pending_words.push_back(mk(OP_ADD, 32'h0A00_0005, 32'h0B00_0000, 32'd200, 6'd0));
      pending_words.push_back(mk(OP_FAIL, 32'h0A00_0005, 32'h0B00_0000, 32'd0, 6'd0));
      pending_words.push_back(mk(OP_ADD, 32'h0A00_0005, 32'h0B00_0000, 32'd200, 6'd0));
      pending_words.push_back(mk(OP_FAIL, 32'h1, 32'h2, 32'd0, 6'd63));
      pending_words.push_back(mk(OP_DEL, 32'h0A00_0045, 32'h0B00_0001, 32'd0, 6'd0));
      pending_words.push_back(mk(OP_DEL, 32'h0A00_0045, 32'h0B00_0001, 32'd0, 6'd0));
      pending_words.push_back(mk(OP_SWEEP, 32'd0, 32'd0, 32'd3700, 6'd5));
      pending_words.push_back(mk(OP_SWEEP, 32'd0, 32'd0, 32'd3701, 6'd5));
      pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0, 32'd0, 6'd5));
      pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0, 32'd0, 6'd63));
      pending_words.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
      pending_words.push_back(mk(3'd5, 32'd0, 32'd0, 32'd0, 6'd0));
      // delete all pairs of one source
      for (int k = 0; k < 3; k++)
         pending_words.push_back(mk(OP_ADD, 32'h0000_0007, 32'h100 + k, 32'd1, 6'd0));
      pending_words.push_back(mk(OP_DEL, 32'h0000_0007, 32'd0, 32'd0, 6'd0));
      wait_drained();

      // random phases over several register settings
      t = 32'hFFFF_FF00;
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_LIFETIME, 32'd0);
               write_csr(CSR_INST_OFF, 32'd1);
            end
            1: write_csr(CSR_LIFETIME, 32'hFFFF_FFFF);
            2: begin
               write_csr(CSR_LIFETIME, 32'd20);
               write_csr(CSR_INST_OFF, 32'd0);
            end
            3: write_csr(CSR_LIFETIME, $urandom());
            default: write_csr(CSR_LIFETIME, 32'd5);
         endcase
         for (int n = 0; n < 29; n++) begin
            t = t + $urandom_range(0, 12);
            pending_words.push_back(random_word(t));
         end
         if (ph == 1) begin
            // receiver holds off while the sender keeps offering
            long_hold = 1;
            hold_cycles = 0;
         end
         if (ph == 3) begin
            // sender pauses until everything is back
            while (pending_words.size() > 17) @(negedge clock);
            pause_send = 1;
            while (req_valid || awaited_results.size() > 0) @(negedge clock);
            pause_send = 0;
         end
         wait_drained();
      end

      $display("covered %0d words, %0d results including %0d removals,",
               words_sent, results_seen, removals_seen);
      $display("five register settings, bucket overflow, aging and failure reports");
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
